### sv/jkve_pkg.sv
// jkve_pkg: shared types and codes for the key/value extractor
// parse modes, result kinds, configuration register indexes, character constants and the result beat type
// no dependencies
package jkve_pkg;

    localparam int KEY_MAX_CHARS_DEF = 16;
    localparam int KEY_CHARS_BITS    = 128;
    localparam int FIFO_DEPTH        = 4;

    // parse modes
    localparam logic [2:0] MODE_SCAN   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_NUMBER = 3'd3;
    localparam logic [2:0] MODE_DONE   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_FOUND    = 2'd1;
    localparam logic [1:0] KIND_NOTFOUND = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_KEY_LOW     = 3'd1;
    localparam logic [2:0] CFG_KEY_HIGH    = 3'd2;
    localparam logic [2:0] CFG_OCCURRENCE  = 3'd3;
    localparam logic [2:0] CFG_VALUE_LIMIT = 3'd4;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_result;

endpackage

### sv/json_key_value_extractor.sv
// json_key_value_extractor: streaming key/value extractor for json-like text
// window match, parse mode update and a small result queue; uses jkve_pkg
//
// channel  direction  handshake                    payload
// input    in         i_in_valid / o_in_ready      i_data_byte, i_end_of_string
// output   out        o_out_valid / i_out_ready    o_out_byte, o_out_kind, o_run_end
// config   in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// one byte per cycle while the input is ready: window compare and mode update are done in
// the accept cycle, and the zero to two result beats land in a four-entry queue read in order.
// the input is ready while at least two queue slots are free, so a stalled output
// side holds the input back once fewer than two queue slots are free.
// synchronous active-low reset clears the window, counters, mode and queue.
module json_key_value_extractor #(
    parameter int KEY_MAX_CHARS = jkve_pkg::KEY_MAX_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_run_end,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import jkve_pkg::*;

    localparam int WIN_DEPTH = KEY_MAX_CHARS + 3;
    localparam int LEN_W     = $clog2(KEY_MAX_CHARS + 1);
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

    // configuration registers
    logic [4:0]                r_key_length;
    logic [KEY_CHARS_BITS-1:0] r_key_chars;
    logic [7:0]                r_occurrence;
    logic [7:0]                r_value_limit;

    // string state
    logic [7:0] r_window [WIN_DEPTH];
    logic [7:0] n_window [WIN_DEPTH];
    logic [7:0] r_match_count, n_match_count;
    logic [2:0] r_mode, n_mode;
    logic [7:0] r_emitted, n_emitted;

    // result queue
    t_result           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic              accept, pop;
    logic [7:0]        sh_window [WIN_DEPTH];
    logic [KEY_MAX_CHARS:0] match_vec;
    logic [LEN_W-1:0]  len_sel;
    logic              pat_match;
    logic              is_num;
    logic              str_end;
    t_result           res_a, res_b;
    logic [1:0]        res_n;

    assign accept = i_in_valid && o_in_ready;
    assign pop    = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_byte  = r_fifo[r_rd_ptr].data;
    assign o_out_kind  = r_fifo[r_rd_ptr].kind;
    assign o_run_end   = r_fifo[r_rd_ptr].last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length  <= 5'd3;
            r_key_chars   <= '0;
            r_occurrence  <= 8'd0;
            r_value_limit <= 8'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LENGTH:  r_key_length  <= i_cfg_data[4:0];
                CFG_KEY_LOW:     r_key_chars[63:0]   <= i_cfg_data;
                CFG_KEY_HIGH:    r_key_chars[127:64] <= i_cfg_data;
                CFG_OCCURRENCE:  r_occurrence  <= i_cfg_data[7:0];
                CFG_VALUE_LIMIT: r_value_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // window with the incoming byte shifted in
    always_comb begin
        sh_window[0] = i_data_byte;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            sh_window[j] = r_window[j-1];
        end
    end

    // pattern compare for every key length in parallel
    always_comb begin
        logic m;
        for (int l = 0; l <= KEY_MAX_CHARS; l++) begin
            m = (sh_window[0] == CH_COLON) && (sh_window[1] == CH_QUOTE)
                && (sh_window[l+2] == CH_QUOTE);
            for (int i = 0; i < l; i++) begin
                if (r_key_chars[i*8 +: 8] == 8'd0 || sh_window[l+1-i] != r_key_chars[i*8 +: 8])
                    m = 1'b0;
            end
            match_vec[l] = m;
        end
    end

    // clamp the key length to the window
    assign len_sel = (r_key_length > 5'(KEY_MAX_CHARS)) ? LEN_W'(KEY_MAX_CHARS)
                                                         : r_key_length[LEN_W-1:0];
    assign pat_match = match_vec[len_sel];
    assign is_num  = ((i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE))
                     || (i_data_byte == CH_DOT);
    assign str_end = (i_data_byte == 8'd0) || i_end_of_string;

    // mode update and result beats for one input beat
    always_comb begin
        t_result r0, r1;
        logic    emit_ok;
        r0 = '0;
        r1 = '0;
        res_n = 2'd0;
        n_window = r_window;
        n_match_count = r_match_count;
        n_mode = r_mode;
        n_emitted = r_emitted;
        emit_ok = (r_emitted < r_value_limit);

        if (accept) begin
            if (i_data_byte != 8'd0) begin
                n_window = sh_window;
                case (r_mode)
                    MODE_SCAN: begin
                        if (pat_match) begin
                            if (r_match_count == r_occurrence)
                                n_mode = MODE_START;
                            else
                                n_match_count = r_match_count + 8'd1;
                        end
                    end
                    MODE_START: begin
                        if (i_data_byte == CH_QUOTE) begin
                            n_mode = MODE_QUOTED;
                        end else if (is_num) begin
                            n_mode = MODE_NUMBER;
                            if (emit_ok) begin
                                r0 = '{data: i_data_byte, kind: KIND_BYTE, last: 1'b0};
                                res_n = 2'd1;
                                n_emitted = r_emitted + 8'd1;
                            end
                        end else begin
                            r0 = '{data: 8'd0, kind: KIND_FOUND, last: 1'b0};
                            res_n = 2'd1;
                            n_mode = MODE_DONE;
                        end
                    end
                    MODE_QUOTED, MODE_NUMBER: begin
                        if ((r_mode == MODE_QUOTED && i_data_byte == CH_QUOTE)
                            || (r_mode == MODE_NUMBER && !is_num)) begin
                            r0 = '{data: 8'd0, kind: KIND_FOUND, last: 1'b0};
                            res_n = 2'd1;
                            n_mode = MODE_DONE;
                        end else if (emit_ok) begin
                            r0 = '{data: i_data_byte, kind: KIND_BYTE, last: 1'b0};
                            res_n = 2'd1;
                            n_emitted = r_emitted + 8'd1;
                        end
                    end
                    default: ;
                endcase
            end

            // string end: completion unless already given, then clear
            if (str_end) begin
                if (n_mode != MODE_DONE) begin
                    if (res_n == 2'd0) begin
                        r0 = '{data: 8'd0,
                               kind: (n_mode == MODE_SCAN) ? KIND_NOTFOUND : KIND_FOUND,
                               last: 1'b0};
                    end else begin
                        r1 = '{data: 8'd0,
                               kind: (n_mode == MODE_SCAN) ? KIND_NOTFOUND : KIND_FOUND,
                               last: 1'b0};
                    end
                    res_n = res_n + 2'd1;
                end
                for (int j = 0; j < WIN_DEPTH; j++) n_window[j] = 8'd0;
                n_match_count = 8'd0;
                n_mode = MODE_SCAN;
                n_emitted = 8'd0;
            end
        end

        // flag the last beat of this input
        if (res_n == 2'd1) r0.last = 1'b1;
        if (res_n == 2'd2) r1.last = 1'b1;
        res_a = r0;
        res_b = r1;
    end

    // string state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WIN_DEPTH; j++) r_window[j] <= 8'd0;
            r_match_count <= 8'd0;
            r_mode        <= MODE_SCAN;
            r_emitted     <= 8'd0;
        end else begin
            r_window      <= n_window;
            r_match_count <= n_match_count;
            r_mode        <= n_mode;
            r_emitted     <= n_emitted;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (res_n != 2'd0) r_fifo[r_wr_ptr] <= res_a;
        if (res_n == 2'd2) r_fifo[r_wr_ptr + PTR_W'(1)] <= res_b;
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(res_n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(res_n) - CNT_W'(pop);
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_nonbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind != KIND_BYTE) |-> (o_out_byte == 8'd0))
        else $error("completion beat carries data");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && str_end) |=> (r_mode == MODE_SCAN && r_match_count == 8'd0
                                 && r_emitted == 8'd0))
        else $error("string end did not clear state");

    a_emit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_n != 2'd0 && res_a.kind == KIND_BYTE) |-> (r_emitted < r_value_limit))
        else $error("value byte past limit");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> (res_n == 2'd0))
        else $error("result without input beat");

endmodule
